>>> sv/ethernet_header_match_filter_assert.svh
// assertion macros for the header match filter top level
`ifndef ETHERNET_HEADER_MATCH_FILTER_ASSERT_SVH
`define ETHERNET_HEADER_MATCH_FILTER_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define EHMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EHMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ehmf_pkg.sv
// shared types, constants and helpers for the header match filter
package ehmf_pkg;

  // protocol address bytes of an ipv4 header
  localparam int unsigned AddrBytes = 4;

  // frame layout
  localparam int unsigned EthHead    = 14;
  localparam int unsigned ArpFixed   = 8;
  localparam int unsigned ArpAddrs   = 22;
  localparam int unsigned KindHiPos  = 12;
  localparam int unsigned KindLoPos  = 13;
  localparam int unsigned HwLenPos   = 18;
  localparam int unsigned ProtoLenPos = 19;
  localparam int unsigned IpProtoPos = 23;
  localparam int unsigned IpSrcPos   = 26;
  localparam int unsigned IpDstPos   = IpSrcPos + AddrBytes;
  localparam int unsigned IpMinLen   = EthHead + 12 + 2 * AddrBytes;
  localparam int unsigned OffsetMax  = 2047;

  localparam logic [15:0] KindArp  = 16'h0806;
  localparam logic [15:0] KindIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;

  // type filter codes
  localparam logic [2:0] TypeNone = 3'd0;
  localparam logic [2:0] TypeArp  = 3'd1;
  localparam logic [2:0] TypeIpv4 = 3'd2;
  localparam logic [2:0] TypeUdp  = 3'd3;
  localparam logic [2:0] TypeTcp  = 3'd4;
  localparam logic [2:0] TypeIcmp = 3'd5;

  // register indexes
  localparam logic [2:0] RegTypeFilter = 3'd0;
  localparam logic [2:0] RegSrcOn      = 3'd1;
  localparam logic [2:0] RegSrcAddr    = 3'd2;
  localparam logic [2:0] RegSrcLen     = 3'd3;
  localparam logic [2:0] RegDstOn      = 3'd4;
  localparam logic [2:0] RegDstAddr    = 3'd5;
  localparam logic [2:0] RegDstLen     = 3'd6;

  typedef logic [10:0] offset_t;

  // configuration as seen by the frame tracker
  typedef struct packed {
    logic [2:0]  type_filter;
    logic        src_on;
    logic [31:0] src_addr;
    logic [2:0]  src_len;
    logic        dst_on;
    logic [31:0] dst_addr;
    logic [2:0]  dst_len;
  } cfg_t;

  // one frame byte handed to the tracker
  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] data;
  } step_t;

  // byte k of a configured address in wire order, zero beyond four bytes
  function automatic logic [7:0] addr_byte(input logic [31:0] addr, input logic [11:0] rel);
    logic [7:0] b;
    unique case (rel[1:0])
      2'd0:    b = addr[31:24];
      2'd1:    b = addr[23:16];
      2'd2:    b = addr[15:8];
      default: b = addr[7:0];
    endcase
    if (rel[11:2] != 10'd0) begin
      b = 8'd0;
    end
    return b;
  endfunction

endpackage

>>> sv/ehmf_cfg_regs.sv
// configuration register file of the header match filter
module ehmf_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_addr_i,
  input  logic [31:0]         cfg_wdata_i,
  output ehmf_pkg::cfg_t      cfg_o
);

  ehmf_pkg::cfg_t cfg_q, cfg_d;

  // registers always take a write
  assign cfg_ready_o = 1'b1;

  // write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        ehmf_pkg::RegTypeFilter: cfg_d.type_filter = cfg_wdata_i[2:0];
        ehmf_pkg::RegSrcOn:      cfg_d.src_on      = cfg_wdata_i[0];
        ehmf_pkg::RegSrcAddr:    cfg_d.src_addr    = cfg_wdata_i;
        ehmf_pkg::RegSrcLen:     cfg_d.src_len     = cfg_wdata_i[2:0];
        ehmf_pkg::RegDstOn:      cfg_d.dst_on      = cfg_wdata_i[0];
        ehmf_pkg::RegDstAddr:    cfg_d.dst_addr    = cfg_wdata_i;
        ehmf_pkg::RegDstLen:     cfg_d.dst_len     = cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_filter <= ehmf_pkg::TypeNone;
      cfg_q.src_on      <= 1'b0;
      cfg_q.src_addr    <= 32'd0;
      cfg_q.src_len     <= 3'd4;
      cfg_q.dst_on      <= 1'b0;
      cfg_q.dst_addr    <= 32'd0;
      cfg_q.dst_len     <= 3'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/ehmf_frame_track.sv
// per-frame header tracking and match verdict
module ehmf_frame_track (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ehmf_pkg::cfg_t   cfg_i,
  input  ehmf_pkg::step_t  step_i,
  output logic             match_o
);

  ehmf_pkg::offset_t offset_q, offset_d;
  logic [15:0] kind_q, kind_d;
  logic [7:0]  hw_len_q, hw_len_d;
  logic [7:0]  proto_len_q, proto_len_d;
  logic [7:0]  ip_proto_q, ip_proto_d;
  logic        src_eq_q, src_eq_d;
  logic        dst_eq_q, dst_eq_d;

  // updated header fields for this byte
  logic [15:0] kind_n;
  logic [7:0]  hw_n, proto_n, ipp_n;
  logic        is_arp, is_ip;
  logic [11:0] pos_w;

  // address windows
  logic [11:0] arp_src_start, arp_dst_start;
  logic [11:0] arp_src_rel, arp_dst_rel, ip_src_rel, ip_dst_rel;
  logic        src_hit, dst_hit;
  logic [11:0] src_rel, dst_rel;
  logic        src_eq_n, dst_eq_n;

  // verdict
  logic [11:0] flen, arp_need;
  logic [7:0]  need_len;
  logic        verdict;

  assign pos_w = {1'b0, offset_q};

  // capture header fields at their offsets
  always_comb begin
    kind_n  = kind_q;
    hw_n    = hw_len_q;
    proto_n = proto_len_q;
    ipp_n   = ip_proto_q;
    if (offset_q == 11'(ehmf_pkg::KindHiPos)) begin
      kind_n = {step_i.data, kind_q[7:0]};
    end
    if (offset_q == 11'(ehmf_pkg::KindLoPos)) begin
      kind_n = {kind_q[15:8], step_i.data};
    end
    if (offset_q == 11'(ehmf_pkg::HwLenPos)) begin
      hw_n = step_i.data;
    end
    if (offset_q == 11'(ehmf_pkg::ProtoLenPos)) begin
      proto_n = step_i.data;
    end
    if (offset_q == 11'(ehmf_pkg::IpProtoPos)) begin
      ipp_n = step_i.data;
    end
  end

  assign is_arp = (kind_n == ehmf_pkg::KindArp);
  assign is_ip  = (kind_n == ehmf_pkg::KindIpv4);

  // arp sender and target windows follow the variable length fields
  assign arp_src_start = 12'(ehmf_pkg::ArpAddrs) + {4'd0, hw_n};
  assign arp_dst_start = 12'(ehmf_pkg::ArpAddrs) + {3'd0, hw_n, 1'b0} + {4'd0, proto_n};
  assign arp_src_rel   = pos_w - arp_src_start;
  assign arp_dst_rel   = pos_w - arp_dst_start;
  assign ip_src_rel    = pos_w - 12'(ehmf_pkg::IpSrcPos);
  assign ip_dst_rel    = pos_w - 12'(ehmf_pkg::IpDstPos);

  // select the active window for each address
  always_comb begin
    src_hit = 1'b0;
    dst_hit = 1'b0;
    src_rel = arp_src_rel;
    dst_rel = arp_dst_rel;
    if (is_arp && pos_w >= 12'(ehmf_pkg::ArpAddrs)) begin
      src_hit = (pos_w >= arp_src_start) && (arp_src_rel < {4'd0, proto_n});
      dst_hit = (pos_w >= arp_dst_start) && (arp_dst_rel < {4'd0, proto_n});
    end else if (is_ip) begin
      src_rel = ip_src_rel;
      dst_rel = ip_dst_rel;
      src_hit = (pos_w >= 12'(ehmf_pkg::IpSrcPos)) &&
                (ip_src_rel < 12'(ehmf_pkg::AddrBytes));
      dst_hit = (pos_w >= 12'(ehmf_pkg::IpDstPos)) &&
                (ip_dst_rel < 12'(ehmf_pkg::AddrBytes));
    end
  end

  // running address compare
  assign src_eq_n = src_eq_q &&
      !(src_hit && (ehmf_pkg::addr_byte(cfg_i.src_addr, src_rel) != step_i.data));
  assign dst_eq_n = dst_eq_q &&
      !(dst_hit && (ehmf_pkg::addr_byte(cfg_i.dst_addr, dst_rel) != step_i.data));

  // length and verdict
  assign flen     = pos_w + 12'd1;
  assign arp_need = 12'(ehmf_pkg::EthHead + ehmf_pkg::ArpFixed) +
                    {3'd0, hw_n, 1'b0} + {3'd0, proto_n, 1'b0};
  assign need_len = is_arp ? proto_n : 8'(ehmf_pkg::AddrBytes);

  always_comb begin
    verdict = 1'b1;
    if (cfg_i.type_filter == ehmf_pkg::TypeNone && !cfg_i.src_on && !cfg_i.dst_on) begin
      verdict = 1'b1;
    end else if (flen < 12'(ehmf_pkg::EthHead)) begin
      verdict = 1'b0;
    end else if (!is_arp && !is_ip) begin
      verdict = 1'b0;
    end else if (is_arp && (flen < 12'(ehmf_pkg::EthHead + ehmf_pkg::ArpFixed) ||
                            flen < arp_need)) begin
      verdict = 1'b0;
    end else if (is_ip && flen < 12'(ehmf_pkg::IpMinLen)) begin
      verdict = 1'b0;
    end else begin
      // type filter
      if (cfg_i.type_filter != ehmf_pkg::TypeNone) begin
        if (is_arp) begin
          if (cfg_i.type_filter != ehmf_pkg::TypeArp) begin
            verdict = 1'b0;
          end
        end else if (cfg_i.type_filter != ehmf_pkg::TypeIpv4) begin
          priority if (ipp_n == ehmf_pkg::ProtoUdp) begin
            if (cfg_i.type_filter != ehmf_pkg::TypeUdp) verdict = 1'b0;
          end else if (ipp_n == ehmf_pkg::ProtoTcp) begin
            if (cfg_i.type_filter != ehmf_pkg::TypeTcp) verdict = 1'b0;
          end else if (ipp_n == ehmf_pkg::ProtoIcmp) begin
            if (cfg_i.type_filter != ehmf_pkg::TypeIcmp) verdict = 1'b0;
          end else begin
            verdict = 1'b0;
          end
        end
      end
      // address filters
      if (cfg_i.src_on && ({5'd0, cfg_i.src_len} != need_len || !src_eq_n)) begin
        verdict = 1'b0;
      end
      if (cfg_i.dst_on && ({5'd0, cfg_i.dst_len} != need_len || !dst_eq_n)) begin
        verdict = 1'b0;
      end
    end
  end

  assign match_o = verdict;

  // frame state next values, cleared after the final byte
  always_comb begin
    offset_d    = offset_q;
    kind_d      = kind_q;
    hw_len_d    = hw_len_q;
    proto_len_d = proto_len_q;
    ip_proto_d  = ip_proto_q;
    src_eq_d    = src_eq_q;
    dst_eq_d    = dst_eq_q;
    if (step_i.fire) begin
      if (step_i.last) begin
        offset_d    = '0;
        kind_d      = '0;
        hw_len_d    = '0;
        proto_len_d = '0;
        ip_proto_d  = '0;
        src_eq_d    = 1'b1;
        dst_eq_d    = 1'b1;
      end else begin
        if (offset_q != 11'(ehmf_pkg::OffsetMax)) begin
          offset_d = offset_q + 11'd1;
        end
        kind_d      = kind_n;
        hw_len_d    = hw_n;
        proto_len_d = proto_n;
        ip_proto_d  = ipp_n;
        src_eq_d    = src_eq_n;
        dst_eq_d    = dst_eq_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      kind_q      <= '0;
      hw_len_q    <= '0;
      proto_len_q <= '0;
      ip_proto_q  <= '0;
      src_eq_q    <= 1'b1;
      dst_eq_q    <= 1'b1;
    end else begin
      offset_q    <= offset_d;
      kind_q      <= kind_d;
      hw_len_q    <= hw_len_d;
      proto_len_q <= proto_len_d;
      ip_proto_q  <= ip_proto_d;
      src_eq_q    <= src_eq_d;
      dst_eq_q    <= dst_eq_d;
    end
  end

endmodule

>>> sv/ethernet_header_match_filter.sv
// top level of the ethernet header match filter
//
//   channel  direction  handshake            payload
//   in       sink       in_valid_i/in_stall_o  data_byte_i, last_byte_i
//   out      source     out_valid_o/out_stall_i frame_matches_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_addr_i, cfg_wdata_i
//
// one word per cycle unless a final byte waits on a stalled output; each word is
// held in the input register; a final byte that moves on loads the output register.
// reset clears the frame state and loads the register reset values.
// only a held final byte waits on a stalled output, and the input stalls behind it;
// any other held byte moves on at once.
// configuration writes are taken in any cycle.
`include "ethernet_header_match_filter_assert.svh"

module ethernet_header_match_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_matches_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  ehmf_pkg::cfg_t  cfg;
  ehmf_pkg::step_t step;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q, out_valid_d;
  logic       out_match_q, out_match_d;
  logic       out_free, fire, in_take, match;

  ehmf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // a held word moves on unless it is a final byte facing a full, stalled output
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && (!in_last_q || out_free);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  assign step.fire = fire;
  assign step.last = in_last_q;
  assign step.data = in_byte_q;

  ehmf_frame_track u_frame_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (step),
    .match_o (match)
  );

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_match_d = out_match_q;
    if (fire && in_last_q) begin
      out_valid_d = 1'b1;
      out_match_d = match;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    out_match_q <= out_match_d;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_matches_o = out_match_q;

  // checks
  `EHMF_ASSERT_NEXT(a_last_gives_verdict, fire && in_last_q, out_valid_q,
                    "final byte did not produce a verdict")
  `EHMF_ASSERT_NOW(a_stall_only_when_held, in_stall_o, in_valid_q,
                   "input stalled with an empty input register")
  `EHMF_ASSERT_NOW(a_middle_never_stalls, in_valid_q && !in_last_q, !in_stall_o,
                   "non-final byte was stalled")
  `EHMF_ASSERT_NOW(a_stall_needs_full_out, in_stall_o, out_valid_q && out_stall_i,
                   "input stalled while the output register could take a verdict")

endmodule

>>> verif/tb_top.sv
// testbench for the header match filter: byte frames in, predicted verdicts checked out
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseWords    = 40;
  localparam logic [2:0]  TypeUnused    = 3'd7;

  localparam ehmf_pkg::cfg_t DefaultCfg = '{type_filter: ehmf_pkg::TypeNone, src_on: 1'b0,
                                            src_addr: 32'd0, src_len: 3'd4, dst_on: 1'b0,
                                            dst_addr: 32'd0, dst_len: 3'd4};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        frame_matches_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i  = ehmf_pkg::RegTypeFilter;
  logic [31:0] cfg_wdata_i = 32'd0;

  ethernet_header_match_filter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_matches_o(frame_matches_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned send_gap_pct = 37;
  int unsigned rx_stall_pct = 79;
  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;

  // mirror of the filter registers and of the per-frame header state
  ehmf_pkg::cfg_t    filt_cfg = DefaultCfg;
  ehmf_pkg::offset_t pos_cnt;
  logic [15:0] kind_seen;
  logic [7:0]  hw_len_seen;
  logic [7:0]  proto_len_seen;
  logic [7:0]  proto_seen;
  logic        src_same;
  logic        dst_same;

  logic        pending_verdicts[$];
  logic [7:0]  frame_buf[$];

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  // verdict checker
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("frame_matches: no verdict expected, actual %0b", frame_matches_o);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (frame_matches_o !== want) begin
          $error("frame_matches: expected %0b, actual %0b", want, frame_matches_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // byte k of an address in wire order, zero past the fourth byte
  function automatic logic [7:0] wire_octet(input logic [31:0] a, input int unsigned k);
    if (k >= 4) return 8'd0;
    return a[31 - 8 * k -: 8];
  endfunction

  function automatic void clear_frame();
    pos_cnt        = '0;
    kind_seen      = 16'd0;
    hw_len_seen    = 8'd0;
    proto_len_seen = 8'd0;
    proto_seen     = 8'd0;
    src_same       = 1'b1;
    dst_same       = 1'b1;
  endfunction

  // verdict for a frame of flen bytes from the state gathered so far
  function automatic logic frame_verdict(input int unsigned flen);
    logic        is_arp;
    logic        is_ip;
    int unsigned need_len;
    if (filt_cfg.type_filter == ehmf_pkg::TypeNone && !filt_cfg.src_on && !filt_cfg.dst_on)
      return 1'b1;
    if (flen < ehmf_pkg::EthHead) return 1'b0;
    is_arp = (kind_seen == ehmf_pkg::KindArp);
    is_ip  = (kind_seen == ehmf_pkg::KindIpv4);
    if (is_arp) begin
      if (flen < ehmf_pkg::EthHead + ehmf_pkg::ArpFixed + 2 * hw_len_seen +
                 2 * proto_len_seen) return 1'b0;
    end else if (is_ip) begin
      if (flen < ehmf_pkg::IpMinLen) return 1'b0;
    end else begin
      return 1'b0;
    end
    if (filt_cfg.type_filter != ehmf_pkg::TypeNone) begin
      if (is_arp) begin
        if (filt_cfg.type_filter != ehmf_pkg::TypeArp) return 1'b0;
      end else if (filt_cfg.type_filter != ehmf_pkg::TypeIpv4) begin
        case (proto_seen)
          ehmf_pkg::ProtoUdp:  if (filt_cfg.type_filter != ehmf_pkg::TypeUdp) return 1'b0;
          ehmf_pkg::ProtoTcp:  if (filt_cfg.type_filter != ehmf_pkg::TypeTcp) return 1'b0;
          ehmf_pkg::ProtoIcmp: if (filt_cfg.type_filter != ehmf_pkg::TypeIcmp) return 1'b0;
          default:             return 1'b0;
        endcase
      end
    end
    need_len = is_arp ? int'(proto_len_seen) : ehmf_pkg::AddrBytes;
    if (filt_cfg.src_on && (filt_cfg.src_len != need_len || !src_same)) return 1'b0;
    if (filt_cfg.dst_on && (filt_cfg.dst_len != need_len || !dst_same)) return 1'b0;
    return 1'b1;
  endfunction

  // advance the header state by one accepted word
  task automatic track_byte(input logic [7:0] d, input logic l);
    int unsigned pos;
    int unsigned src_at;
    int unsigned dst_at;
    int unsigned span;
    logic        in_zone;
    pos = pos_cnt;
    case (pos)
      ehmf_pkg::KindHiPos:   kind_seen[15:8] = d;
      ehmf_pkg::KindLoPos:   kind_seen[7:0]  = d;
      ehmf_pkg::HwLenPos:    hw_len_seen     = d;
      ehmf_pkg::ProtoLenPos: proto_len_seen  = d;
      default: ;
    endcase
    if (pos == ehmf_pkg::IpProtoPos) proto_seen = d;
    in_zone = 1'b0;
    if (kind_seen == ehmf_pkg::KindArp && pos >= ehmf_pkg::ArpAddrs) begin
      in_zone = 1'b1;
      src_at  = ehmf_pkg::ArpAddrs + hw_len_seen;
      dst_at  = ehmf_pkg::ArpAddrs + 2 * hw_len_seen + proto_len_seen;
      span    = proto_len_seen;
    end else if (kind_seen == ehmf_pkg::KindIpv4) begin
      in_zone = 1'b1;
      src_at  = ehmf_pkg::IpSrcPos;
      dst_at  = ehmf_pkg::IpDstPos;
      span    = ehmf_pkg::AddrBytes;
    end
    if (in_zone) begin
      if (pos >= src_at && pos - src_at < span &&
          wire_octet(filt_cfg.src_addr, pos - src_at) != d)
        src_same = 1'b0;
      if (pos >= dst_at && pos - dst_at < span &&
          wire_octet(filt_cfg.dst_addr, pos - dst_at) != d)
        dst_same = 1'b0;
    end
    if (l) begin
      pending_verdicts.push_back(frame_verdict(pos + 1));
      clear_frame();
    end else if (pos_cnt < ehmf_pkg::OffsetMax) begin
      pos_cnt = pos_cnt + 1'b1;
    end
  endtask

  // one word on the input channel, with random gaps ahead of it
  task automatic send_word(input logic [7:0] d, input logic l);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    track_byte(d, l);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_word(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // hold the sender until every verdict is back
  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // write all seven registers while the block is idle
  task automatic load_config(input ehmf_pkg::cfg_t c);
    logic [2:0]  regs[7];
    logic [31:0] vals[7];
    regs = '{ehmf_pkg::RegTypeFilter, ehmf_pkg::RegSrcOn, ehmf_pkg::RegSrcAddr,
             ehmf_pkg::RegSrcLen, ehmf_pkg::RegDstOn, ehmf_pkg::RegDstAddr,
             ehmf_pkg::RegDstLen};
    vals = '{32'(c.type_filter), 32'(c.src_on), c.src_addr, 32'(c.src_len),
             32'(c.dst_on), c.dst_addr, 32'(c.dst_len)};
    drain_verdicts();
    repeat (DrainCycles) @(posedge clk_i);
    for (int i = 0; i < 7; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= regs[i];
      cfg_wdata_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    filt_cfg = c;
  endtask

  // frame building
  task automatic push_rand(input int unsigned n);
    repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic trim_frame(input int unsigned n);
    while (frame_buf.size() > n) void'(frame_buf.pop_back());
  endtask

  task automatic start_frame(input logic [15:0] kind);
    frame_buf.delete();
    push_rand(12);
    frame_buf.push_back(kind[15:8]);
    frame_buf.push_back(kind[7:0]);
  endtask

  function automatic logic [7:0] addr_field(input logic [31:0] a, input int unsigned k,
                                            input logic hit);
    return hit ? wire_octet(a, k) : 8'($urandom_range(0, 255));
  endfunction

  task automatic build_arp(input int unsigned hlen, input int unsigned plen,
                           input logic src_hit, input logic dst_hit);
    start_frame(ehmf_pkg::KindArp);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h01);
    frame_buf.push_back(8'h08);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'(hlen));
    frame_buf.push_back(8'(plen));
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'($urandom_range(1, 2)));
    push_rand(hlen);
    for (int k = 0; k < plen; k++)
      frame_buf.push_back(addr_field(filt_cfg.src_addr, k, src_hit));
    push_rand(hlen);
    for (int k = 0; k < plen; k++)
      frame_buf.push_back(addr_field(filt_cfg.dst_addr, k, dst_hit));
  endtask

  task automatic build_ipv4(input logic [7:0] proto, input logic src_hit, input logic dst_hit);
    start_frame(ehmf_pkg::KindIpv4);
    frame_buf.push_back(8'h45);
    // tos, total length, id, flags and ttl
    push_rand(8);
    frame_buf.push_back(proto);
    push_rand(2);
    for (int k = 0; k < ehmf_pkg::AddrBytes; k++)
      frame_buf.push_back(addr_field(filt_cfg.src_addr, k, src_hit));
    for (int k = 0; k < ehmf_pkg::AddrBytes; k++)
      frame_buf.push_back(addr_field(filt_cfg.dst_addr, k, dst_hit));
  endtask

  // mostly well-formed headers with random content, some noise and cut frames
  task automatic build_random_frame();
    int unsigned pick;
    int unsigned hlen;
    int unsigned plen;
    logic [7:0]  proto;
    logic        hit_s;
    logic        hit_d;
    pick  = $urandom_range(0, 99);
    hit_s = ($urandom_range(0, 3) != 0);
    hit_d = ($urandom_range(0, 3) != 0);
    if (pick < 40) begin
      case ($urandom_range(0, 4))
        0:       proto = ehmf_pkg::ProtoUdp;
        1:       proto = ehmf_pkg::ProtoTcp;
        2:       proto = ehmf_pkg::ProtoIcmp;
        default: proto = 8'($urandom_range(0, 255));
      endcase
      build_ipv4(proto, hit_s, hit_d);
    end else if (pick < 75) begin
      pick = $urandom_range(0, 99);
      hlen = (pick < 75) ? 6 : (pick < 95) ? $urandom_range(0, 10) : $urandom_range(0, 255);
      pick = $urandom_range(0, 99);
      if (pick < 70)
        plen = filt_cfg.src_on ? filt_cfg.src_len : filt_cfg.dst_on ? filt_cfg.dst_len : 4;
      else if (pick < 95)
        plen = $urandom_range(0, 8);
      else
        plen = $urandom_range(0, 255);
      build_arp(hlen, plen, hit_s, hit_d);
    end else if (pick < 90) begin
      start_frame(16'($urandom_range(0, 65535)));
      push_rand($urandom_range(0, 50));
    end else begin
      // noise with a plausible ethertype now and then
      frame_buf.delete();
      push_rand($urandom_range(1, 64));
      if (frame_buf.size() > 13 && $urandom_range(0, 1)) begin
        frame_buf[12] = 8'h08;
        frame_buf[13] = $urandom_range(0, 1) ? ehmf_pkg::KindArp[7:0] :
                                               ehmf_pkg::KindIpv4[7:0];
      end
    end
    push_rand($urandom_range(0, 10));
    if ($urandom_range(0, 99) < 15) trim_frame($urandom_range(1, frame_buf.size()));
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic ehmf_pkg::cfg_t random_cfg();
    ehmf_pkg::cfg_t c;
    c.type_filter = 3'($urandom_range(0, 5));
    c.src_on      = 1'($urandom_range(0, 1));
    c.src_addr    = pick_addr();
    c.src_len     = ($urandom_range(0, 3) != 0) ? 3'd4 : 3'($urandom_range(0, 4));
    c.dst_on      = 1'($urandom_range(0, 1));
    c.dst_addr    = pick_addr();
    c.dst_len     = ($urandom_range(0, 3) != 0) ? 3'd4 : 3'($urandom_range(0, 4));
    return c;
  endfunction

  // no filter set: anything passes, however short or odd
  task automatic test_no_filter();
    load_config(DefaultCfg);
    frame_buf = '{8'hFF};
    send_frame();
    frame_buf.delete();
    repeat (5) frame_buf.push_back(8'h00);
    send_frame();
    start_frame(16'hFFFF);
    push_rand(4);
    send_frame();
  endtask

  // type codes against frames they want and frames they do not, with short ipv4 frames
  task automatic test_type_select();
    ehmf_pkg::cfg_t c;
    c = DefaultCfg;
    c.type_filter = ehmf_pkg::TypeArp;
    load_config(c);
    build_arp(0, 4, 1'b0, 1'b0);
    send_frame();
    build_ipv4(ehmf_pkg::ProtoUdp, 1'b0, 1'b0);
    send_frame();
    // arp cut one byte short of its address section
    build_arp(0, 4, 1'b0, 1'b0);
    trim_frame(frame_buf.size() - 1);
    send_frame();
    c.type_filter = ehmf_pkg::TypeIpv4;
    load_config(c);
    build_ipv4(ehmf_pkg::ProtoIcmp, 1'b0, 1'b0);
    send_frame();
    // ipv4 one byte under the minimum header, then a frame shorter than ethernet
    build_ipv4(ehmf_pkg::ProtoTcp, 1'b0, 1'b0);
    trim_frame(ehmf_pkg::IpMinLen - 1);
    send_frame();
    build_ipv4(ehmf_pkg::ProtoTcp, 1'b0, 1'b0);
    trim_frame(ehmf_pkg::EthHead - 1);
    send_frame();
    c.type_filter = ehmf_pkg::TypeUdp;
    load_config(c);
    build_ipv4(ehmf_pkg::ProtoUdp, 1'b0, 1'b0);
    send_frame();
    build_ipv4(ehmf_pkg::ProtoTcp, 1'b0, 1'b0);
    send_frame();
    c.type_filter = ehmf_pkg::TypeTcp;
    load_config(c);
    build_ipv4(ehmf_pkg::ProtoTcp, 1'b0, 1'b0);
    send_frame();
    build_arp(0, 4, 1'b0, 1'b0);
    send_frame();
    c.type_filter = ehmf_pkg::TypeIcmp;
    load_config(c);
    build_ipv4(ehmf_pkg::ProtoIcmp, 1'b0, 1'b0);
    send_frame();
    build_ipv4(8'hFF, 1'b0, 1'b0);
    send_frame();
    // unused type code rejects everything
    c.type_filter = TypeUnused;
    load_config(c);
    build_arp(0, 4, 1'b0, 1'b0);
    send_frame();
  endtask

  // address compare, length mismatch and zero-length addresses
  task automatic test_address_filters();
    ehmf_pkg::cfg_t c;
    c = DefaultCfg;
    c.src_on   = 1'b1;
    c.src_addr = 32'hFFFF_FFFF;
    load_config(c);
    build_ipv4(ehmf_pkg::ProtoTcp, 1'b1, 1'b0);
    send_frame();
    build_ipv4(ehmf_pkg::ProtoTcp, 1'b0, 1'b0);
    send_frame();
    c.src_on = 1'b0;
    c.dst_on = 1'b1;
    load_config(c);
    build_arp(6, 4, 1'b0, 1'b1);
    send_frame();
    // six-byte protocol address: bytes past four compare with zero, length differs
    build_arp(6, 6, 1'b0, 1'b1);
    send_frame();
    c.dst_len = 3'd0;
    load_config(c);
    build_arp(0, 0, 1'b0, 1'b0);
    send_frame();
    c.src_on  = 1'b1;
    c.src_len = 3'd4;
    c.dst_len = 3'd4;
    load_config(c);
    build_ipv4(ehmf_pkg::ProtoUdp, 1'b1, 1'b1);
    send_frame();
  endtask

  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct);
    int unsigned words;
    words = 0;
    send_gap_pct = gap_pct;
    rx_stall_pct = stall_pct;
    load_config(random_cfg());
    while (words < PhaseWords) begin
      build_random_frame();
      words += frame_buf.size();
      send_frame();
      if ($urandom_range(0, 9) == 0) drain_verdicts();
    end
  endtask

  initial begin
    clear_frame();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_filter();
    test_type_select();
    test_address_filters();
    test_random_traffic(37, 79);
    test_random_traffic(79, 37);
    test_random_traffic(0, 0);
    drain_verdicts();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
